// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the port-level checker of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ----- rtl/ctsw_pkg.sv -----
// ---------------------------------------------------------------------------
// ctsw_pkg
// Types, codes, sizes and the control store of the swap walk core.
// ---------------------------------------------------------------------------
package ctsw_pkg;

  // table geometry
  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SLOTS      = 4;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int PC_W       = 4;

  localparam logic [COUNT_BITS-1:0] CELL_MAX = '1;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_SAME   = 3'd1,
    ST_REJECT = 3'd2,
    ST_STUCK  = 3'd3,
    ST_BAD    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_FROW = 2'd2,
    CFG_FCOL = 2'd3
  } cfg_idx_e;

  // input word
  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] row_label;
    logic [4:0] col_label;
    logic [3:0] read_row;
    logic [3:0] read_col;
    logic [3:0] row_offset_a;
    logic [3:0] row_offset_b;
    logic [3:0] pick_col_a;
    logic [3:0] pick_col_b;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] cell_value;
  } result_t;

  // configuration as seen by the decoder
  typedef struct packed {
    logic [4:0] rows_in_use;
    logic [4:0] cols_in_use;
    logic [3:0] frozen_row;
    logic [3:0] frozen_col;
  } cfg_t;

  // decoder verdict and the cell addresses of one item
  // slot 0 (i1,j2), slot 1 (i2,j1), slot 2 (i1,j1), slot 3 (i2,j2);
  // count and read use slot 0 only
  typedef struct packed {
    status_e                      status;
    logic [SLOTS-1:0][ADDR_W-1:0] addr;
  } decode_t;

  // jump conditions of the microprogram
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_FAIL,
    C_READ,
    C_COUNT,
    C_NO_MOVE,
    C_SAT0
  } cond_e;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              cap_en;
    logic [SLOT_W-1:0] cap_slot;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic              wr_inc;
    cond_e             cond;
    logic [PC_W-1:0]   target;
    logic              fin;
  } ctrl_t;

  // program addresses
  localparam logic [PC_W-1:0] PC_CHK_CNT = PC_W'(11);
  localparam logic [PC_W-1:0] PC_FIN     = PC_W'(13);

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

  function automatic ctrl_t cw(input logic rd_en, input int rd_slot,
                               input logic cap_en, input int cap_slot,
                               input logic wr_en, input int wr_slot,
                               input logic wr_inc, input cond_e cond,
                               input logic [PC_W-1:0] target, input logic fin);
    ctrl_t c;
    c.rd_en    = rd_en;
    c.rd_slot  = SLOT_W'(rd_slot);
    c.cap_en   = cap_en;
    c.cap_slot = SLOT_W'(cap_slot);
    c.wr_en    = wr_en;
    c.wr_slot  = SLOT_W'(wr_slot);
    c.wr_inc   = wr_inc;
    c.cond     = cond;
    c.target   = target;
    c.fin      = fin;
    return c;
  endfunction

  // control store: reads, check, then writes; count and read share the head
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    unique case (pc)
      4'd0:    c = cw(1'b1, 0, 1'b0, 0, 1'b0, 0, 1'b0, C_FAIL,    PC_FIN,     1'b0);
      4'd1:    c = cw(1'b1, 1, 1'b1, 0, 1'b0, 0, 1'b0, C_READ,    PC_FIN,     1'b0);
      4'd2:    c = cw(1'b0, 0, 1'b0, 0, 1'b0, 0, 1'b0, C_COUNT,   PC_CHK_CNT, 1'b0);
      4'd3:    c = cw(1'b1, 2, 1'b1, 1, 1'b0, 0, 1'b0, C_NONE,    PC_FIN,     1'b0);
      4'd4:    c = cw(1'b1, 3, 1'b1, 2, 1'b0, 0, 1'b0, C_NONE,    PC_FIN,     1'b0);
      4'd5:    c = cw(1'b0, 0, 1'b1, 3, 1'b0, 0, 1'b0, C_NONE,    PC_FIN,     1'b0);
      4'd6:    c = cw(1'b0, 0, 1'b0, 0, 1'b0, 0, 1'b0, C_NO_MOVE, PC_FIN,     1'b0);
      4'd7:    c = cw(1'b0, 0, 1'b0, 0, 1'b1, 0, 1'b0, C_NONE,    PC_FIN,     1'b0);
      4'd8:    c = cw(1'b0, 0, 1'b0, 0, 1'b1, 1, 1'b0, C_NONE,    PC_FIN,     1'b0);
      4'd9:    c = cw(1'b0, 0, 1'b0, 0, 1'b1, 2, 1'b1, C_NONE,    PC_FIN,     1'b0);
      4'd10:   c = cw(1'b0, 0, 1'b0, 0, 1'b1, 3, 1'b1, C_ALWAYS,  PC_FIN,     1'b0);
      4'd11:   c = cw(1'b0, 0, 1'b0, 0, 1'b0, 0, 1'b0, C_SAT0,    PC_FIN,     1'b0);
      4'd12:   c = cw(1'b0, 0, 1'b0, 0, 1'b1, 0, 1'b1, C_NONE,    PC_FIN,     1'b0);
      4'd13:   c = cw(1'b0, 0, 1'b0, 0, 1'b0, 0, 1'b0, C_NONE,    PC_FIN,     1'b1);
      default: c = cw(1'b0, 0, 1'b0, 0, 1'b0, 0, 1'b0, C_ALWAYS,  PC_FIN,     1'b0);
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ctsw_ram.sv -----
// ---------------------------------------------------------------------------
// ctsw_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module ctsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/ctsw_decode.sv -----
// ---------------------------------------------------------------------------
// ctsw_decode
// Range checks, frozen-point handling and cell addresses for one word.
// ---------------------------------------------------------------------------
module ctsw_decode (
  input  ctsw_pkg::cmd_t    cmd_i,
  input  ctsw_pkg::cfg_t    cfg_i,
  output ctsw_pkg::decode_t dec_o
);
  import ctsw_pkg::*;

  logic [4:0] n, m;
  logic [4:0] k, span;
  logic [3:0] l;
  logic [3:0] i1, i2;
  logic       col_end;
  logic       stuck, bad_pick, touches;
  logic [4:0] rl_m1, cl_m1;

  // clamp the sizes to 1..max
  always_comb begin
    if (cfg_i.rows_in_use == 5'd0) n = 5'd1;
    else if (cfg_i.rows_in_use > 5'(MAX_ROWS)) n = 5'(MAX_ROWS);
    else n = cfg_i.rows_in_use;
    if (cfg_i.cols_in_use == 5'd0) m = 5'd1;
    else if (cfg_i.cols_in_use > 5'(MAX_COLS)) m = 5'(MAX_COLS);
    else m = cfg_i.cols_in_use;
  end

  // effective frozen point, wraps to the next row at the last column
  assign col_end = {1'b0, cfg_i.frozen_col} >= (m - 5'd1);
  assign k       = col_end ? ({1'b0, cfg_i.frozen_row} + 5'd1) : {1'b0, cfg_i.frozen_row};
  assign l       = col_end ? 4'd0 : cfg_i.frozen_col;
  assign stuck   = (m < 5'd2) || (({1'b0, k} + 6'd1) >= {1'b0, n});
  assign span    = n - k;
  assign i1      = k[3:0] + cmd_i.row_offset_a;
  assign i2      = k[3:0] + cmd_i.row_offset_b;

  assign bad_pick = ({1'b0, cmd_i.row_offset_a} >= span) ||
                    ({1'b0, cmd_i.row_offset_b} >= span) ||
                    (cmd_i.row_offset_a == cmd_i.row_offset_b) ||
                    ({1'b0, cmd_i.pick_col_a} >= m) ||
                    ({1'b0, cmd_i.pick_col_b} >= m) ||
                    (cmd_i.pick_col_a == cmd_i.pick_col_b);

  assign touches = ((cmd_i.row_offset_a == 4'd0) || (cmd_i.row_offset_b == 4'd0)) &&
                   ((cmd_i.pick_col_a < l) || (cmd_i.pick_col_b < l));

  assign rl_m1 = cmd_i.row_label - 5'd1;
  assign cl_m1 = cmd_i.col_label - 5'd1;

  // verdict and addresses per operation
  always_comb begin
    dec_o.status = ST_BAD;
    dec_o.addr   = '0;
    unique case (op_e'(cmd_i.operation))
      OP_COUNT: begin
        dec_o.addr[0] = cell_addr(ROW_W'(rl_m1), COL_W'(cl_m1));
        if (cmd_i.row_label != 5'd0 && cmd_i.row_label <= n &&
            cmd_i.col_label != 5'd0 && cmd_i.col_label <= m) begin
          dec_o.status = ST_DONE;
        end
      end
      OP_STEP: begin
        dec_o.addr[0] = cell_addr(ROW_W'(i1), COL_W'(cmd_i.pick_col_b));
        dec_o.addr[1] = cell_addr(ROW_W'(i2), COL_W'(cmd_i.pick_col_a));
        dec_o.addr[2] = cell_addr(ROW_W'(i1), COL_W'(cmd_i.pick_col_a));
        dec_o.addr[3] = cell_addr(ROW_W'(i2), COL_W'(cmd_i.pick_col_b));
        priority if (stuck) dec_o.status = ST_STUCK;
        else if (bad_pick)  dec_o.status = ST_BAD;
        else if (touches)   dec_o.status = ST_REJECT;
        else                dec_o.status = ST_DONE;
      end
      OP_READ: begin
        dec_o.addr[0] = cell_addr(ROW_W'(cmd_i.read_row), COL_W'(cmd_i.read_col));
        if ({1'b0, cmd_i.read_row} < n && {1'b0, cmd_i.read_col} < m) begin
          dec_o.status = ST_DONE;
        end
      end
      OP_NONE: dec_o.status = ST_BAD;
    endcase
  end

endmodule

// ----- rtl/contingency_table_swap_walk_core.sv -----
// ---------------------------------------------------------------------------
// contingency_table_swap_walk_core
// Count table with count, swap-move and read operations, microcoded control.
// ---------------------------------------------------------------------------
// One word is taken when start_i is high and busy_o is low; exactly one
// result word follows, shown on result_o for a single cycle with done_o
// high. There is no backpressure on the result side, so the receiver must
// take every word in that cycle. A new word may be started in the same cycle
// a result is shown. All cells of the table read as zero after reset without
// a clearing pass. A read fetches its cell and finishes; a count fetches its
// cell, checks it and writes it back one higher unless it is already at the
// top; a swap move runs four reads, a check and four writes, stopping after
// the check when it finds a zero or full cell; a word refused by the range
// or frozen-point checks goes straight to the finish step. These steps run
// on the single table RAM under the microprogram in the control store.
// Configuration writes are always ready and must be done while idle.
// ---------------------------------------------------------------------------
module contingency_table_swap_walk_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  ctsw_pkg::cmd_t    cmd_i,
  output logic              done_o,
  output ctsw_pkg::result_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [4:0]        cfg_data_i
);
  import ctsw_pkg::*;

  cfg_t                         cfg_q;
  decode_t                      dec;
  logic                         running_q;
  logic [PC_W-1:0]              pc_q;
  op_e                          op_q;
  status_e                      status_q;
  logic [SLOTS-1:0][ADDR_W-1:0] addr_q;
  logic [COUNT_BITS-1:0]        slot_q [SLOTS];
  logic [DEPTH-1:0]             valid_q;
  logic                         rd_vld_q;
  logic                         done_q;
  result_t                      result_q;

  ctrl_t                        ctl;
  logic                         taken;
  logic                         re, we;
  logic [ADDR_W-1:0]            raddr, waddr;
  logic [COUNT_BITS-1:0]        wdata, rdata, rd_value, wr_src;
  logic                         accept;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_in_use <= 5'(MAX_ROWS);
      cfg_q.cols_in_use <= 5'(MAX_COLS);
      cfg_q.frozen_row  <= 4'd0;
      cfg_q.frozen_col  <= 4'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROWS: cfg_q.rows_in_use <= cfg_data_i;
        CFG_COLS: cfg_q.cols_in_use <= cfg_data_i;
        CFG_FROW: cfg_q.frozen_row  <= cfg_data_i[3:0];
        CFG_FCOL: cfg_q.frozen_col  <= cfg_data_i[3:0];
      endcase
    end
  end

  ctsw_decode u_decode (
    .cmd_i (cmd_i),
    .cfg_i (cfg_q),
    .dec_o (dec)
  );

  // control word and jump decision
  assign ctl = ucode(pc_q);

  always_comb begin
    unique case (ctl.cond)
      C_NONE:    taken = 1'b0;
      C_ALWAYS:  taken = 1'b1;
      C_FAIL:    taken = (status_q != ST_DONE);
      C_READ:    taken = (op_q == OP_READ);
      C_COUNT:   taken = (op_q == OP_COUNT);
      C_NO_MOVE: taken = (slot_q[0] == '0) || (slot_q[1] == '0) ||
                         (slot_q[2] == CELL_MAX) || (slot_q[3] == CELL_MAX);
      C_SAT0:    taken = (slot_q[0] == CELL_MAX);
      default:   taken = 1'b0;
    endcase
  end

  // table memory ports
  assign accept   = start_i && !running_q;
  assign re       = running_q && ctl.rd_en;
  assign raddr    = addr_q[ctl.rd_slot];
  assign we       = running_q && ctl.wr_en;
  assign waddr    = addr_q[ctl.wr_slot];
  assign wr_src   = slot_q[ctl.wr_slot];
  assign wdata    = ctl.wr_inc ? (wr_src + COUNT_BITS'(1)) : (wr_src - COUNT_BITS'(1));
  assign rd_value = rd_vld_q ? rdata : '0;

  ctsw_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // per-cell written flags, an unwritten cell reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) valid_q[waddr] <= 1'b1;
      if (re) rd_vld_q <= valid_q[raddr];
    end
  end

  // sequencer state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pc_q      <= '0;
      done_q    <= 1'b0;
      op_q      <= OP_NONE;
      status_q  <= ST_DONE;
    end else begin
      done_q <= 1'b0;
      if (accept) begin
        running_q <= 1'b1;
        pc_q      <= '0;
        op_q      <= op_e'(cmd_i.operation);
        status_q  <= dec.status;
      end else if (running_q) begin
        pc_q <= taken ? ctl.target : (pc_q + PC_W'(1));
        if (taken && (ctl.cond == C_NO_MOVE || ctl.cond == C_SAT0)) begin
          status_q <= ST_SAME;
        end
        if (ctl.fin) begin
          running_q <= 1'b0;
          done_q    <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= dec.addr;
    end
    if (running_q && ctl.cap_en) begin
      slot_q[ctl.cap_slot] <= rd_value;
    end
    if (running_q && ctl.fin) begin
      result_q.status     <= status_q;
      result_q.cell_value <= (op_q == OP_READ && status_q == ST_DONE) ?
                             16'(slot_q[0]) : 16'd0;
    end
  end

  assign busy_o   = running_q;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- rtl/ctsw_checker.sv -----
// ---------------------------------------------------------------------------
// ctsw_checker
// Port-level checks of the swap walk core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ctsw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input ctsw_pkg::result_t result_o
);
  import ctsw_pkg::*;

  // an accepted word makes the core busy
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "accept without busy")

  // a result closes the busy period
  `ASSERT_IMPLY(a_done_idle, clk_i, rst_ni, done_o, !busy_o && $past(busy_o), "done while busy")

  // one strobe per word
  `ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "done held two cycles")

  // only a successful word carries a value
  `ASSERT_IMPLY(a_value_ok, clk_i, rst_ni, done_o && result_o.cell_value != 16'd0, result_o.status == ST_DONE, "value on failed word")

endmodule

bind contingency_table_swap_walk_core ctsw_checker u_ctsw_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

// ----- test/ctsw_table_checker.sv -----
// ---------------------------------------------------------------------------
// ctsw_table_checker
// Watches the command, result and register channels of the swap walk core,
// keeps its own copy of the count table, predicts each result word and
// compares it field by field with what the core shows.
// ---------------------------------------------------------------------------
module ctsw_table_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  ctsw_pkg::cmd_t    cmd_i,
  input  logic              done_i,
  input  ctsw_pkg::result_t result_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [4:0]        cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import ctsw_pkg::*;

  // mirrored table and register contents
  logic [COUNT_BITS-1:0] cell_count [MAX_ROWS][MAX_COLS];
  logic [4:0]            rows_cfg;
  logic [4:0]            cols_cfg;
  logic [3:0]            frow_cfg;
  logic [3:0]            fcol_cfg;

  // result words owed by the core, oldest first
  result_t due_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count_o < 30) begin
      $display("mismatch at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
    fail_count_o++;
  endtask

  function automatic int clamp_dim(input logic [4:0] v, input int top);
    if (v == 5'd0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // apply one accepted word to the mirrored table and form its result word
  task automatic apply_word(input cmd_t w, output result_t res);
    int      n;
    int      m;
    int      k;
    int      l;
    int      i1;
    int      i2;
    int      j1;
    int      j2;
    int      rl;
    int      cl;
    status_e st;
    logic [15:0] val;
    n   = clamp_dim(rows_cfg, MAX_ROWS);
    m   = clamp_dim(cols_cfg, MAX_COLS);
    st  = ST_BAD;
    val = '0;
    case (w.operation)
      OP_COUNT: begin
        rl = int'(w.row_label);
        cl = int'(w.col_label);
        if (rl >= 1 && rl <= n && cl >= 1 && cl <= m) begin
          if (cell_count[rl-1][cl-1] == CELL_MAX) begin
            st = ST_SAME;
          end else begin
            cell_count[rl-1][cl-1]++;
            st = ST_DONE;
          end
        end
      end
      OP_STEP: begin
        k  = int'(frow_cfg);
        l  = int'(fcol_cfg);
        j1 = int'(w.pick_col_a);
        j2 = int'(w.pick_col_b);
        if (m < 2) begin
          st = ST_STUCK;
        end else begin
          // frozen point at the row end moves to the next row
          if (l >= m - 1) begin
            k++;
            l = 0;
          end
          if (k + 1 >= n) begin
            st = ST_STUCK;
          end else if (int'(w.row_offset_a) >= n - k || int'(w.row_offset_b) >= n - k ||
                       w.row_offset_a == w.row_offset_b ||
                       j1 >= m || j2 >= m || j1 == j2) begin
            st = ST_BAD;
          end else begin
            i1 = k + int'(w.row_offset_a);
            i2 = k + int'(w.row_offset_b);
            if ((i1 == k || i2 == k) && (j1 < l || j2 < l)) begin
              st = ST_REJECT;
            end else if (cell_count[i1][j2] == '0 || cell_count[i2][j1] == '0 ||
                         cell_count[i1][j1] == CELL_MAX ||
                         cell_count[i2][j2] == CELL_MAX) begin
              st = ST_SAME;
            end else begin
              cell_count[i1][j2]--;
              cell_count[i2][j1]--;
              cell_count[i1][j1]++;
              cell_count[i2][j2]++;
              st = ST_DONE;
            end
          end
        end
      end
      OP_READ: begin
        if (int'(w.read_row) < n && int'(w.read_col) < m) begin
          st  = ST_DONE;
          val = cell_count[w.read_row][w.read_col];
        end
      end
      default: ;
    endcase
    res.status     = st;
    res.cell_value = val;
  endtask

  // per-edge bookkeeping: result first, so a word started in the result
  // cycle lines up behind it
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int r = 0; r < MAX_ROWS; r++) begin
        for (int c = 0; c < MAX_COLS; c++) begin
          cell_count[r][c] = '0;
        end
      end
      rows_cfg = 5'd16;
      cols_cfg = 5'd16;
      frow_cfg = 4'd0;
      fcol_cfg = 4'd0;
      due_results.delete();
    end else begin
      // result word shown this cycle
      if (done_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result word with nothing outstanding, status",
                          int'(result_i.status), -1);
        end else begin
          want = due_results.pop_front();
          if (result_i.status !== want.status) begin
            report_mismatch("status", int'(result_i.status), int'(want.status));
          end
          if (result_i.cell_value !== want.cell_value) begin
            report_mismatch("cell_value", int'(result_i.cell_value),
                            int'(want.cell_value));
          end
        end
      end
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ROWS: rows_cfg = cfg_data_i;
          CFG_COLS: cols_cfg = cfg_data_i;
          CFG_FROW: frow_cfg = cfg_data_i[3:0];
          CFG_FCOL: fcol_cfg = cfg_data_i[3:0];
          default: ;
        endcase
      end
      // command word taken
      if (start_i && !busy_i) begin
        apply_word(cmd_i, want);
        due_results.push_back(want);
      end
    end
    pending_o = due_results.size();
  end

endmodule

// ----- test/contingency_table_swap_walk_core_tb.sv -----
// ---------------------------------------------------------------------------
// contingency_table_swap_walk_core_tb
// Drives count, swap-move, read and undefined words into the swap walk core
// across several table settings: a directed opening, the corner cells of the
// full table, then random words shaped to the current geometry. A separate
// checker predicts and compares every result word.
// ---------------------------------------------------------------------------
module contingency_table_swap_walk_core_tb;
  import ctsw_pkg::*;

  localparam int PHASES     = 8;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    start     = 1'b0;
  cmd_t    cmd       = '0;
  logic    cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data  = '0;
  logic    busy;
  logic    done;
  result_t result;
  logic    cfg_ready;
  int      fail_count;
  int      pending;

  // geometry in force, used to shape random words
  int n_use = 16;
  int m_use = 16;
  int k_eff = 0;
  int settings_run = 0;
  int word_tally [4] = '{0, 0, 0, 0};
  bit idle_on = 1'b0;

  // table settings of the random part, extremes included
  int set_rows [PHASES] = '{16, 3, 4, 2, 31, 5,  0, 0};
  int set_cols [PHASES] = '{16, 3, 5, 2,  2, 16, 0, 0};
  int set_frow [PHASES] = '{ 0, 0, 1, 0, 13, 2, 15, 0};
  int set_fcol [PHASES] = '{ 0, 0, 2, 0,  1, 15, 15, 0};

  always #1 clk = ~clk;

  contingency_table_swap_walk_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .cmd_i       (cmd),
    .done_o      (done),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ctsw_table_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .done_i       (done),
    .result_i     (result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // word with random content in every field, operation set
  function automatic cmd_t noise_word(input op_e op);
    logic [63:0] raw;
    cmd_t        w;
    raw         = {$urandom, $urandom};
    w           = raw[$bits(cmd_t)-1:0];
    w.operation = op;
    return w;
  endfunction

  function automatic cmd_t count_word(input int rl, input int cl);
    cmd_t w;
    w           = noise_word(OP_COUNT);
    w.row_label = 5'(rl);
    w.col_label = 5'(cl);
    return w;
  endfunction

  function automatic cmd_t step_word(input int oa, input int ob, input int ja, input int jb);
    cmd_t w;
    w              = noise_word(OP_STEP);
    w.row_offset_a = 4'(oa);
    w.row_offset_b = 4'(ob);
    w.pick_col_a   = 4'(ja);
    w.pick_col_b   = 4'(jb);
    return w;
  endfunction

  function automatic cmd_t read_word(input int r, input int c);
    cmd_t w;
    w          = noise_word(OP_READ);
    w.read_row = 4'(r);
    w.read_col = 4'(c);
    return w;
  endfunction

  // hand one word over; called and returns at a falling edge
  task automatic send_word(input cmd_t w);
    if (idle_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 36);
    end
    start <= 1'b1;
    cmd   <= w;
    word_tally[w.operation]++;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // wait until every owed result word has come and the core is free
  task automatic settle();
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 5'(val);
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
  endtask

  // new table setting, written only while the core is idle
  task automatic set_table(input int rows, input int cols, input int frow, input int fcol);
    start <= 1'b0;
    settle();
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_FROW, frow);
    write_reg(CFG_FCOL, fcol);
    cfg_valid <= 1'b0;
    n_use = (rows < 1) ? 1 : (rows > MAX_ROWS) ? MAX_ROWS : rows;
    m_use = (cols < 1) ? 1 : (cols > MAX_COLS) ? MAX_COLS : cols;
    k_eff = (fcol >= m_use - 1) ? frow + 1 : frow;
    settings_run++;
  endtask

  // mostly well-formed words for the current geometry, some noise
  task automatic random_word();
    cmd_t w;
    int   pick;
    int   span;
    int   oa;
    int   ob;
    int   ja;
    int   jb;
    pick = $urandom_range(99);
    span = n_use - k_eff;
    if (pick < 40) begin
      if ($urandom_range(9) != 0) begin
        w = count_word($urandom_range(1, n_use), $urandom_range(1, m_use));
      end else begin
        w = noise_word(OP_COUNT);
      end
    end else if (pick < 80) begin
      if (m_use >= 2 && span >= 2 && $urandom_range(9) != 0) begin
        oa = $urandom_range(0, span - 1);
        ob = (oa + $urandom_range(1, span - 1)) % span;
        ja = $urandom_range(0, m_use - 1);
        jb = (ja + $urandom_range(1, m_use - 1)) % m_use;
        w  = step_word(oa, ob, ja, jb);
      end else begin
        w = noise_word(OP_STEP);
      end
    end else if (pick < 95) begin
      if ($urandom_range(6) != 0) begin
        w = read_word($urandom_range(0, n_use - 1), $urandom_range(0, m_use - 1));
      end else begin
        w = noise_word(OP_READ);
      end
    end else begin
      w = noise_word(OP_NONE);
    end
    send_word(w);
  endtask

  // run limit
  initial begin
    #200_000;
    $display("run stopped: no progress within the time limit");
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reads, label range, a swap and its refusals, undefined op
    send_word(read_word(0, 0));
    send_word(read_word(15, 15));
    send_word(count_word(1, 1));
    send_word(count_word(16, 16));
    send_word(count_word(0, 5));
    send_word(count_word(5, 0));
    send_word(count_word(17, 3));
    send_word(count_word(31, 31));
    send_word(count_word(1, 2));
    send_word(count_word(2, 1));
    send_word(step_word(0, 1, 0, 1));
    send_word(step_word(0, 1, 0, 1));
    send_word(step_word(2, 2, 0, 1));
    send_word(step_word(0, 1, 3, 3));
    send_word(step_word(0, 15, 15, 0));
    send_word(read_word(0, 0));
    send_word(noise_word(OP_NONE));

    // single column, then single row: nothing movable
    set_table(31, 1, 0, 0);
    send_word(step_word(0, 1, 0, 1));
    set_table(0, 16, 0, 0);
    send_word(step_word(0, 1, 0, 1));
    send_word(count_word(2, 1));
    send_word(read_word(1, 0));

    // frozen point inside the table: refused picks and range errors
    set_table(4, 4, 1, 2);
    send_word(step_word(0, 1, 0, 3));
    send_word(step_word(3, 0, 0, 1));
    send_word(step_word(1, 2, 4, 0));
    // frozen column at the row end
    set_table(4, 4, 1, 3);
    send_word(step_word(0, 1, 0, 1));
    set_table(4, 4, 2, 3);
    send_word(step_word(0, 1, 0, 1));

    // corner cells of the full table, without gaps
    set_table(16, 16, 0, 0);
    send_word(count_word(1, 16));
    send_word(count_word(16, 1));
    send_word(count_word(16, 16));
    send_word(read_word(15, 15));
    send_word(step_word(0, 15, 0, 15));
    send_word(step_word(15, 0, 15, 0));
    send_word(step_word(0, 15, 15, 0));
    send_word(read_word(15, 15));
    send_word(count_word(16, 16));
    send_word(read_word(15, 15));

    // random part over several settings, with idling
    idle_on = 1'b1;
    set_rows[PHASES-1] = $urandom_range(2, 8);
    set_cols[PHASES-1] = $urandom_range(2, 8);
    set_frow[PHASES-1] = $urandom_range(0, 3);
    set_fcol[PHASES-1] = $urandom_range(0, 7);
    for (int p = 0; p < PHASES; p++) begin
      set_table(set_rows[p], set_cols[p], set_frow[p], set_fcol[p]);
      repeat ((set_rows[p] == 0) ? 20 : 80) random_word();
    end

    // drain and give the verdict
    start <= 1'b0;
    settle();
    repeat (20) @(negedge clk);
    $display("covered %0d count, %0d swap step, %0d read and %0d undefined words",
             word_tally[OP_COUNT], word_tally[OP_STEP], word_tally[OP_READ],
             word_tally[OP_NONE]);
    $display("over %0d table settings, corner cells and frozen points included",
             settings_run);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ctsw_pkg.sv
rtl/ctsw_ram.sv
rtl/ctsw_decode.sv
rtl/contingency_table_swap_walk_core.sv
rtl/ctsw_checker.sv
test/ctsw_table_checker.sv
test/contingency_table_swap_walk_core_tb.sv
